// ===== rtl/b64d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants for the base64 stream decoder
// Symbol decode, group geometry and the job record passed front to back.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned SextetW   = 6;
  localparam int unsigned AccW      = 3 * SextetW;   // three pending sextets
  localparam int unsigned GroupW    = 4 * SextetW;   // one full group, three bytes
  localparam int unsigned ByteW     = 8;
  localparam int unsigned JobDepth  = 4;             // default job queue depth

  localparam logic [ByteW-1:0] PadChar = 8'h3D;      // '='

  typedef struct packed {
    logic               hit;
    logic [SextetW-1:0] val;
  } sextet_t;

  // One unit of back-end work: up to three bytes of a group, MSB first.
  // nbytes of zero on a final job means a bare end marker.
  typedef struct packed {
    logic [GroupW-1:0] data;
    logic [1:0]        nbytes;
    logic              last;
    logic              bad;
  } job_t;

  function automatic sextet_t sextet_of(input logic [ByteW-1:0] ch);
    sextet_t          s;
    logic [ByteW-1:0] off;
    s   = '0;
    off = '0;
    if (ch inside {["A":"Z"]}) begin
      off   = ch - 8'h41;
      s.hit = 1'b1;
      s.val = off[SextetW-1:0];
    end else if (ch inside {["a":"z"]}) begin
      off   = ch - 8'h61 + 8'd26;
      s.hit = 1'b1;
      s.val = off[SextetW-1:0];
    end else if (ch inside {["0":"9"]}) begin
      off   = ch - 8'h30 + 8'd52;
      s.hit = 1'b1;
      s.val = off[SextetW-1:0];
    end else if (ch == 8'h2B) begin
      s.hit = 1'b1;
      s.val = 6'd62;
    end else if (ch == 8'h2F) begin
      s.hit = 1'b1;
      s.val = 6'd63;
    end
    return s;
  endfunction

endpackage

// ===== rtl/base64_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming base64 (standard alphabet) decoder
// One character per cycle while full_o is low; decoded bytes out via a queue port.
// ----------------------------------------------------------------------------
// Takes one character per cycle (push_i while full_o is low); characters
// outside A-Z a-z 0-9 + / are skipped, '=' only counts as padding on the last
// two raw characters of a text, and is_last_i closes the text and returns the
// decoder to its reset state for the next one. Every fourth symbol yields
// three bytes, MSB first; the final character yields the padded tail bytes,
// or a bare end marker (byte_valid_o low) when nothing is left, and the last
// result of the text carries end_of_data_o, with bad_length_o set when an
// incomplete trailing group was discarded. The first result of a character
// passes through the job queue and then the output register. Results
// leave at one per cycle while pop_i keeps up, from a single output register
// fed by the byte sequencer, so a stream of valid symbols (0.75 bytes per
// character) is taken at full rate indefinitely; full_o only rises when the
// JOB_DEPTH-entry job queue between classifier and sequencer fills, i.e.
// when the result side is held off with pop_i.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
  parameter int unsigned JOB_DEPTH = b64d_pkg::JobDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic [b64d_pkg::ByteW-1:0] in_char_i,
  input  logic                       is_last_i,
  output logic                       empty_o,
  input  logic                       pop_i,
  output logic [b64d_pkg::ByteW-1:0] out_byte_o,
  output logic                       byte_valid_o,
  output logic                       end_of_data_o,
  output logic                       bad_length_o
);

  localparam int unsigned JobW = $bits(b64d_pkg::job_t);

  logic           accept;
  logic           fr_job_valid;
  b64d_pkg::job_t fr_job;
  logic [JobW-1:0] q_rdata;
  b64d_pkg::job_t q_job;
  logic           q_empty, q_full, q_pop;

  assign accept = push_i && !q_full;
  assign full_o = q_full;

  // front: classify characters and build groups
  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .in_char_i   (in_char_i),
    .is_last_i   (is_last_i),
    .job_valid_o (fr_job_valid),
    .job_o       (fr_job)
  );

  // decoupling queue; full here is what backpressures the character input
  b64d_job_queue #(
    .WIDTH (JobW),
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_job_valid),
    .data_i  (fr_job),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign q_job = q_rdata;

  // back: one byte per cycle into the result register, as pop_i allows
  b64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (!q_empty),
    .job_i         (q_job),
    .job_pop_o     (q_pop),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .end_of_data_o (end_of_data_o),
    .bad_length_o  (bad_length_o)
  );

  // a bare marker only ever closes a text
  a_marker_is_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !byte_valid_o) |-> end_of_data_o)
    else $error("end marker without end_of_data");

  // length error is reported on the closing result only
  a_bad_on_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && bad_length_o) |-> end_of_data_o)
    else $error("bad_length on a non-final result");

  // a final character always leaves work behind it
  a_last_makes_job : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_last_i) |=> !q_empty)
    else $error("final character produced no job");

  // the front never offers a job to a full queue
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_job_valid |-> !q_full)
    else $error("job pushed into full queue");

endmodule

// ===== rtl/b64d_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front: character classifier and sextet accumulator
// Gathers symbols into groups and issues one job per completed group or end.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [b64d_pkg::ByteW-1:0]     in_char_i,
  input  logic                           is_last_i,
  output logic                           job_valid_o,
  output b64d_pkg::job_t                 job_o
);

  logic [b64d_pkg::AccW-1:0] acc_q, acc_d, acc_n;
  logic [1:0]                cnt_q, cnt_d, cnt_n;
  logic                      pad_q, pad_d;
  logic                      grp_full, is_pad;
  logic [1:0]                pads;
  logic [2:0]                total;
  b64d_pkg::sextet_t         sx;

  always_comb begin
    sx       = b64d_pkg::sextet_of(in_char_i);
    is_pad   = (in_char_i == b64d_pkg::PadChar);
    grp_full = 1'b0;
    acc_n    = acc_q;
    cnt_n    = cnt_q;
    if (sx.hit) begin
      if (cnt_q == 2'd3) begin
        grp_full = 1'b1;
        acc_n    = '0;
        cnt_n    = '0;
      end else begin
        acc_n = {acc_q[b64d_pkg::AccW-b64d_pkg::SextetW-1:0], sx.val};
        cnt_n = cnt_q + 2'd1;
      end
    end
    pads  = {1'b0, is_pad} + {1'b0, pad_q};
    total = {1'b0, cnt_n} + {1'b0, pads};
  end

  always_comb begin
    job_o       = '0;
    job_valid_o = 1'b0;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    pad_d       = pad_q;
    if (valid_i) begin
      if (grp_full) begin
        job_o.data   = {acc_q, sx.val};
        job_o.nbytes = 2'd3;
      end
      if (is_last_i) begin
        job_o.last = 1'b1;
        if (!grp_full && total == 3'd4) begin
          // padded tail: two or three sextets, one or two bytes kept
          job_o.nbytes = 2'd3 - pads;
          case (cnt_n)
            2'd3:    job_o.data = {acc_n, 6'b0};
            2'd2:    job_o.data = {acc_n[11:0], 12'b0};
            default: job_o.data = '0;
          endcase
        end else begin
          job_o.bad = (total != 3'd0);
        end
        acc_d = '0;
        cnt_d = '0;
        pad_d = 1'b0;
      end else begin
        acc_d = acc_n;
        cnt_d = cnt_n;
        pad_d = is_pad;
      end
      job_valid_o = grp_full | is_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
      pad_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      pad_q <= pad_d;
    end
  end

endmodule

// ===== rtl/b64d_job_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_job_queue: small FIFO of jobs between front and back
// Register based, first-word-fall-through on the read side.
// ----------------------------------------------------------------------------
module b64d_job_queue #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/b64d_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back: byte sequencer and output register
// Walks the head job into a single result stage, one byte per cycle as pop_i allows.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  input  b64d_pkg::job_t             job_i,
  output logic                       job_pop_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [b64d_pkg::ByteW-1:0] out_byte_o,
  output logic                       byte_valid_o,
  output logic                       end_of_data_o,
  output logic                       bad_length_o
);

  logic [1:0]                idx_q, idx_d;
  logic                      out_vld_q, out_vld_d;
  logic [b64d_pkg::ByteW-1:0] byte_q, byte_d;
  logic                      bv_q, eod_q, bad_q, bv_d, eod_d, bad_d;
  logic                      load, at_end;
  logic [1:0]                n_res;

  always_comb begin
    load   = job_valid_i && (!out_vld_q || pop_i);
    n_res  = (job_i.nbytes == 2'd0) ? 2'd1 : job_i.nbytes;
    at_end = (idx_q == n_res - 2'd1);
    bv_d   = (job_i.nbytes != 2'd0);
    eod_d  = job_i.last && at_end;
    bad_d  = job_i.bad && at_end;
    case (idx_q)
      2'd0:    byte_d = job_i.data[23:16];
      2'd1:    byte_d = job_i.data[15:8];
      2'd2:    byte_d = job_i.data[7:0];
      default: byte_d = '0;
    endcase
    if (!bv_d) begin
      byte_d = '0;
    end
    job_pop_o = load && at_end;
    idx_d     = idx_q;
    if (load) begin
      idx_d = at_end ? 2'd0 : idx_q + 2'd1;
    end
    out_vld_d = load ? 1'b1 : (pop_i ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      bv_q   <= bv_d;
      eod_q  <= eod_d;
      bad_q  <= bad_d;
    end
  end

  assign empty_o       = !out_vld_q;
  assign out_byte_o    = byte_q;
  assign byte_valid_o  = bv_q;
  assign end_of_data_o = eod_q;
  assign bad_length_o  = bad_q;

endmodule
